FILE: design/assert_macros.svh
// Assertion macros shared by the RTL files; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked outside reset, on the rising edge of clk.
`define NRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define NRP_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NRP_ASSERT(lbl, prop, msg)
`define NRP_ASSERT_ALL(lbl, prop, msg)
`endif
`endif

FILE: design/nrp_pkg.sv
// Shared types and constants of the nonce range partitioner.
`timescale 1ns / 1ps
`default_nettype none

package nrp_pkg;

    // Field widths.
    localparam int COUNT_W  = 5;
    localparam int WORKER_W = 8;
    localparam int CMD_W    = 2;
    localparam int NONCE_W  = 32;
    localparam int PCT_W    = 7;

    // Width of the 100 * done product and of the shared subtractor.
    localparam int REM_W = 39;
    localparam int SUB_W = 40;

    // Default number of counters.
    localparam int MAX_WORKERS_DEF = 16;

    // Worker count after reset.
    localparam int RESET_COUNT = 4;

    localparam logic [NONCE_W-1:0] FULL_SPACE = 32'hFFFF_FFFF;
    localparam logic [PCT_W-1:0]   PCT_SCALE  = 7'd100;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_NEXT      = 2'd0,
        CMD_RESET_ONE = 2'd1,
        CMD_RESET_ALL = 2'd2,
        CMD_QUERY     = 2'd3
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/nonce_range_partitioner.sv
// Nonce range partitioner: per-worker nonce counters over equal slices of the 32-bit space.
//
//  channel   | direction | tdata (low bit up)                 | tuser
//  ----------+-----------+------------------------------------+-----------------
//  s_*       | in        | worker[7:0]                        | command[1:0]
//  m_*       | out       | nonce[31:0], progress_percent[38:32] | status[0]
//  worker_count | cfg    | worker_count[4:0] written when worker_count_we is high
//
// A word with a good worker index occupies the block from its acceptance to
// the next acceptance: the accept cycle, slice start multiply, counter update,
// 100 * done multiply, seven steps of the shared subtractor for the percent
// quotient, and the output load, which waits while the output register is full.
// A bad worker index, or a reset of all workers with an index past the count,
// skips the multiply and the divide. A worker_count write runs a 32-step divide
// of 0xFFFFFFFF by the count on the same subtractor, and s_tready stays low for
// the write and the divide. After reset the slices for four workers are ready at once.
// The block holds a finished word in its output register and takes the next
// input word meanwhile; it waits for the output only when the next result is done.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nonce_range_partitioner #(
    parameter int MAX_WORKERS = nrp_pkg::MAX_WORKERS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         worker_count_we,
    input  wire logic [nrp_pkg::COUNT_W-1:0]  worker_count,

    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [7:0]                   s_tdata,  // worker[7:0]
    input  wire logic [1:0]                   s_tuser,  // command[1:0]

    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    output      logic [39:0]                  m_tdata,  // nonce[31:0], progress_percent[38:32]
    output      logic [0:0]                   m_tuser   // status[0]
);

    localparam int IDX_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int RESET_N = (MAX_WORKERS < nrp_pkg::RESET_COUNT) ?
                             MAX_WORKERS : nrp_pkg::RESET_COUNT;
    localparam logic [31:0] RESET_SLICE = 32'(64'hFFFF_FFFF / RESET_N);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_UPDATE,
        S_MUL,
        S_DIV,
        S_DONE,
        S_WDIV
    } state_t;

    state_t                              state_reg;
    logic [nrp_pkg::COUNT_W-1:0]         n_reg;
    logic [31:0]                         slice_width_reg;
    logic [MAX_WORKERS-1:0]              vld_reg;
    logic [31:0]                         nonce_mem [MAX_WORKERS];

    nrp_pkg::cmd_t                       cmd_reg;
    logic [nrp_pkg::WORKER_W-1:0]        worker_reg;
    logic [31:0]                         start_reg;
    logic [31:0]                         cur_raw_reg;
    logic                                cur_vld_reg;
    logic [32:0]                         total_reg;
    logic [31:0]                         done_reg;
    logic [nrp_pkg::REM_W-1:0]           rem_reg;
    logic [nrp_pkg::REM_W-1:0]           dsr_reg;
    logic [31:0]                         quo_reg;
    logic [4:0]                          step_reg;
    logic                                status_hold_reg;
    logic [31:0]                         nonce_hold_reg;
    logic [nrp_pkg::PCT_W-1:0]           pct_hold_reg;

    logic                                m_tvalid_reg;
    logic                                status_reg;
    logic [31:0]                         nonce_reg;
    logic [nrp_pkg::PCT_W-1:0]           pct_reg;

    logic [IDX_W-1:0]                    idx;
    logic [nrp_pkg::COUNT_W-1:0]         n_clamp;
    logic                                in_range;
    logic                                last_slice;
    logic [31:0]                         cur;
    logic [32:0]                         end33;
    logic [32:0]                         adv33;
    logic [31:0]                         new_nonce;
    logic [36:0]                         start_prod;
    logic [nrp_pkg::SUB_W-1:0]           sub_a;
    logic [nrp_pkg::SUB_W-1:0]           sub_b;
    logic [nrp_pkg::SUB_W:0]             sub_diff;
    logic                                sub_ge;
    logic                                accept;
    logic                                out_load;

    assign idx    = worker_reg[IDX_W-1:0];
    assign accept = s_tvalid && s_tready;

    // A finished word moves into the output register once that register is free.
    assign out_load = (state_reg == S_DONE) && !worker_count_we && (!m_tvalid_reg || m_tready);

    // Clamp a written count into 1..MAX_WORKERS.
    always_comb
    begin
        if (worker_count == '0)
            n_clamp = nrp_pkg::COUNT_W'(1);
        else if (32'(worker_count) > 32'(MAX_WORKERS))
            n_clamp = nrp_pkg::COUNT_W'(MAX_WORKERS);
        else
            n_clamp = worker_count;
    end

    // Slice start of the addressed worker; indices past the count are never used.
    assign start_prod = 37'(slice_width_reg) * 37'(worker_reg[nrp_pkg::COUNT_W-1:0]);

    // Counter update for the addressed worker.
    always_comb
    begin
        in_range   = worker_reg < nrp_pkg::WORKER_W'(n_reg);
        last_slice = worker_reg == (nrp_pkg::WORKER_W'(n_reg) - 8'd1);
        cur        = cur_vld_reg ? cur_raw_reg : start_reg;
        end33      = last_slice ? {1'b0, nrp_pkg::FULL_SPACE}
                                : {1'b0, start_reg + slice_width_reg - 32'd1};
        adv33      = {1'b0, cur} + 33'd1;
        unique case (cmd_reg)
            nrp_pkg::CMD_NEXT:      new_nonce = (adv33 > end33) ? start_reg : adv33[31:0];
            nrp_pkg::CMD_RESET_ONE: new_nonce = start_reg;
            nrp_pkg::CMD_RESET_ALL: new_nonce = start_reg;
            nrp_pkg::CMD_QUERY:     new_nonce = cur;
            default:                new_nonce = cur;
        endcase
    end

    // Shared subtract and compare unit for both restoring divides.
    always_comb
    begin
        if (state_reg == S_WDIV)
            sub_a = {rem_reg, 1'b1};
        else
            sub_a = {1'b0, rem_reg};
        sub_b    = {1'b0, dsr_reg};
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = ~sub_diff[nrp_pkg::SUB_W];
    end

    // Counter storage; a counter with its valid bit clear reads as its slice start.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_START)
        begin
            cur_raw_reg <= nonce_mem[idx];
        end
        if (state_reg == S_UPDATE && in_range && cmd_reg != nrp_pkg::CMD_RESET_ALL)
        begin
            nonce_mem[idx] <= new_nonce;
        end
    end

    // Sequencer, datapath registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            n_reg           <= nrp_pkg::COUNT_W'(RESET_N);
            slice_width_reg <= RESET_SLICE;
            vld_reg         <= '0;
            cmd_reg         <= nrp_pkg::CMD_NEXT;
            worker_reg      <= '0;
            start_reg       <= '0;
            cur_vld_reg     <= 1'b0;
            total_reg       <= '0;
            done_reg        <= '0;
            rem_reg         <= '0;
            dsr_reg         <= '0;
            quo_reg         <= '0;
            step_reg        <= '0;
            status_hold_reg <= 1'b0;
            nonce_hold_reg  <= '0;
            pct_hold_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
            status_reg      <= 1'b0;
            nonce_reg       <= '0;
            pct_reg         <= '0;
        end
        else
        begin
            // The output word is replaced on a load and leaves on a completed handshake.
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (worker_count_we)
            begin
                // New count: clear all counters and divide the space again.
                n_reg     <= n_clamp;
                vld_reg   <= '0;
                rem_reg   <= '0;
                dsr_reg   <= nrp_pkg::REM_W'(n_clamp);
                quo_reg   <= '0;
                step_reg  <= 5'd31;
                state_reg <= S_WDIV;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (accept)
                        begin
                            cmd_reg    <= nrp_pkg::cmd_t'(s_tuser);
                            worker_reg <= s_tdata;
                            state_reg  <= S_START;
                        end
                    end
                    S_START:
                    begin
                        start_reg   <= start_prod[31:0];
                        cur_vld_reg <= vld_reg[idx];
                        state_reg   <= S_UPDATE;
                    end
                    S_UPDATE:
                    begin
                        status_hold_reg <= (cmd_reg != nrp_pkg::CMD_RESET_ALL) && !in_range;
                        nonce_hold_reg  <= (cmd_reg == nrp_pkg::CMD_NEXT && in_range) ? cur : '0;
                        pct_hold_reg    <= '0;
                        total_reg       <= end33 - {1'b0, start_reg} + 33'd1;
                        done_reg        <= new_nonce - start_reg;
                        if (cmd_reg == nrp_pkg::CMD_RESET_ALL)
                        begin
                            vld_reg   <= '0;
                            state_reg <= in_range ? S_MUL : S_DONE;
                        end
                        else if (!in_range)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            vld_reg[idx] <= 1'b1;
                            state_reg    <= S_MUL;
                        end
                    end
                    S_MUL:
                    begin
                        rem_reg   <= nrp_pkg::REM_W'(done_reg) *
                                     nrp_pkg::REM_W'(nrp_pkg::PCT_SCALE);
                        dsr_reg   <= {total_reg, 6'b0};
                        quo_reg   <= '0;
                        step_reg  <= 5'd6;
                        state_reg <= S_DIV;
                    end
                    S_DIV:
                    begin
                        // One quotient bit of 100 * done / total per cycle.
                        rem_reg <= sub_ge ? sub_diff[nrp_pkg::REM_W-1:0] : rem_reg;
                        dsr_reg <= dsr_reg >> 1;
                        quo_reg <= {quo_reg[30:0], sub_ge};
                        step_reg <= step_reg - 5'd1;
                        if (step_reg == '0)
                        begin
                            pct_hold_reg <= {quo_reg[5:0], sub_ge};
                            state_reg    <= S_DONE;
                        end
                    end
                    S_DONE:
                    begin
                        if (!m_tvalid_reg || m_tready)
                        begin
                            status_reg   <= status_hold_reg;
                            nonce_reg    <= nonce_hold_reg;
                            pct_reg      <= pct_hold_reg;
                            state_reg    <= S_IDLE;
                        end
                    end
                    S_WDIV:
                    begin
                        // One quotient bit of 0xFFFFFFFF / count per cycle.
                        rem_reg  <= sub_ge ? sub_diff[nrp_pkg::REM_W-1:0]
                                           : sub_a[nrp_pkg::REM_W-1:0];
                        quo_reg  <= {quo_reg[30:0], sub_ge};
                        step_reg <= step_reg - 5'd1;
                        if (step_reg == '0)
                        begin
                            slice_width_reg <= {quo_reg[30:0], sub_ge};
                            state_reg       <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // Ports.
    assign s_tready = (state_reg == S_IDLE) && !worker_count_we;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, pct_reg, nonce_reg};
    assign m_tuser  = status_reg;

    // Checks on the sequencer and result.
    `NRP_ASSERT(a_pct_max, m_tvalid |-> (m_tdata[38:32] <= nrp_pkg::PCT_SCALE), "progress above 100")
    `NRP_ASSERT(a_err_zero, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0), "error word not zero")
    `NRP_ASSERT(a_one_item, accept |=> !s_tready, "second word taken while busy")
    `NRP_ASSERT(a_cfg_busy, worker_count_we |=> (!s_tready && slice_width_reg != '0), "cfg rebuild")
    `NRP_ASSERT_ALL(a_rst_quiet, !rst_n |-> !m_tvalid, "output valid in reset")

endmodule

`default_nettype wire
